// File: rtl/wsl_pkg.sv
// ----------------------------------------------------------------------------
// Wrapped segment lookup package
// Shared types and constants of the wrapped segment lookup block.
// ----------------------------------------------------------------------------
package wsl_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_W         = 32;
    localparam int WIDE_W          = 33;
    localparam int COUNT_W         = 7;
    localparam int INDEX_W         = 6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_ENTRY_COUNT  = 2'd0;
    localparam logic [1:0] REG_CLOSED_CURVE = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_RD_LAST,
        ST_LATCH_LAST,
        ST_DIV,
        ST_WRAP,
        ST_SEARCH,
        ST_RD_NEXT,
        ST_RESULT,
        ST_OUT
    } t_state;

    // Request from the sequencer to the table memory.
    typedef struct packed {
        logic        wr_en;
        logic [11:0] addr;
        logic [31:0] wdata;
    } t_mem_req;

endpackage

// File: rtl/wsl_table.sv
// ----------------------------------------------------------------------------
// Wrapped segment lookup table
// Single-port breakpoint memory with a registered read.
// ----------------------------------------------------------------------------
module wsl_table #(
    parameter int TABLE_DEPTH = wsl_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ADDR_W-1:0]             i_addr,
    input  logic [wsl_pkg::VALUE_W-1:0]   i_wdata,
    output logic [wsl_pkg::VALUE_W-1:0]   o_rdata
);

    logic [wsl_pkg::VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [wsl_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/wsl_divider.sv
// ----------------------------------------------------------------------------
// Wrapped segment lookup divider
// Radix-2 restoring divider giving the remainder of two 33-bit values.
// ----------------------------------------------------------------------------
module wsl_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wsl_pkg::WIDE_W-1:0]   i_num,
    input  logic [wsl_pkg::WIDE_W-1:0]   i_den,
    output logic                         o_done,
    output logic [wsl_pkg::WIDE_W-1:0]   o_rem
);

    localparam int W = wsl_pkg::WIDE_W;

    logic [W-1:0]         r_quot;
    logic [W:0]           r_rem;
    logic [W-1:0]         r_den;
    logic [5:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [W:0]           shifted;
    logic [W:0]           diff;

    assign shifted = {r_rem[W-1:0], r_quot[W-1]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem  <= diff;
                r_quot <= {r_quot[W-2:0], 1'b1};
            end else begin
                r_rem  <= shifted;
                r_quot <= {r_quot[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[W-1:0];

endmodule

// File: rtl/wsl_ctrl.sv
// ----------------------------------------------------------------------------
// Wrapped segment lookup sequencer
// Reads the table, wraps the query on a closed curve and walks the entries one per cycle.
// ----------------------------------------------------------------------------
module wsl_ctrl #(
    parameter int TABLE_DEPTH = wsl_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [wsl_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic [wsl_pkg::VALUE_W-1:0]   i_value,
    input  logic [wsl_pkg::COUNT_W-1:0]   i_entry_count,
    input  logic                          i_closed_curve,
    output logic                          o_mem_wr_en,
    output logic [ADDR_W-1:0]             o_mem_addr,
    output logic [wsl_pkg::VALUE_W-1:0]   o_mem_wdata,
    input  logic [wsl_pkg::VALUE_W-1:0]   i_mem_rdata,
    output logic                          o_div_start,
    output logic [wsl_pkg::WIDE_W-1:0]    o_div_num,
    output logic [wsl_pkg::WIDE_W-1:0]    o_div_den,
    input  logic                          i_div_done,
    input  logic [wsl_pkg::WIDE_W-1:0]    i_div_rem,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wsl_pkg::INDEX_W-1:0]   o_segment_index,
    output logic [wsl_pkg::WIDE_W-1:0]    o_segment_offset,
    output logic [wsl_pkg::WIDE_W-1:0]    o_segment_length,
    output logic                          o_error_flag,
    output logic                          o_busy
);

    localparam int W  = wsl_pkg::WIDE_W;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    wsl_pkg::t_state r_state, n_state;

    logic signed [W-1:0]  r_g, r_first, r_last, r_cur;
    logic [W-1:0]         r_span;
    logic                 r_below;
    logic [CW-1:0]        r_n;
    logic [CW-1:0]        r_pos;
    logic                 r_out_valid;
    logic [wsl_pkg::INDEX_W-1:0] r_seg_index;
    logic [W-1:0]         r_seg_offset, r_seg_length;
    logic                 r_err;

    logic [CW-1:0]        n_clamp;
    logic signed [W-1:0]  rd_ext;
    logic                 accept;
    logic                 out_free;

    assign rd_ext   = W'(signed'(i_mem_rdata));
    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (int'(i_entry_count) > TABLE_DEPTH) begin
            n_clamp = CW'(TABLE_DEPTH);
        end else begin
            n_clamp = CW'(i_entry_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_mem_wr_en = 1'b0;
        o_mem_addr  = '0;
        o_mem_wdata = i_value;
        o_div_start = 1'b0;
        case (r_state)
            wsl_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_mem_addr = '0;
                if (i_in_valid) begin
                    if (i_cmd == wsl_pkg::CMD_WRITE) begin
                        o_mem_addr = ADDR_W'(i_entry_index);
                        o_mem_wr_en = ({{(W - wsl_pkg::INDEX_W){1'b0}}, i_entry_index}
                                       < W'(TABLE_DEPTH));
                    end else if (n_clamp < CW'(2)) begin
                        n_state = wsl_pkg::ST_OUT;
                    end else begin
                        n_state = wsl_pkg::ST_RD_FIRST;
                    end
                end
            end
            wsl_pkg::ST_RD_FIRST: begin
                o_mem_addr = ADDR_W'(r_n - CW'(1));
                n_state = wsl_pkg::ST_RD_LAST;
            end
            wsl_pkg::ST_RD_LAST: begin
                o_mem_addr = ADDR_W'(r_n - CW'(1));
                n_state = wsl_pkg::ST_LATCH_LAST;
            end
            wsl_pkg::ST_LATCH_LAST: begin
                o_mem_addr = ADDR_W'(1);
                if (!i_closed_curve) begin
                    n_state = wsl_pkg::ST_SEARCH;
                end else if (rd_ext <= r_first) begin
                    n_state = wsl_pkg::ST_SEARCH;
                end else if (r_g < r_first || r_g > rd_ext) begin
                    o_div_start = 1'b1;
                    n_state = wsl_pkg::ST_DIV;
                end else begin
                    n_state = wsl_pkg::ST_SEARCH;
                end
            end
            wsl_pkg::ST_DIV: begin
                o_mem_addr = ADDR_W'(1);
                if (i_div_done) begin
                    n_state = wsl_pkg::ST_WRAP;
                end
            end
            wsl_pkg::ST_WRAP: begin
                o_mem_addr = ADDR_W'(1);
                n_state = wsl_pkg::ST_SEARCH;
            end
            wsl_pkg::ST_SEARCH: begin
                o_mem_addr = ADDR_W'(r_pos + CW'(1));
                if (r_pos < r_n && rd_ext <= r_g) begin
                    n_state = wsl_pkg::ST_SEARCH;
                end else begin
                    o_mem_addr = (r_pos >= r_n) ? ADDR_W'(r_n - CW'(2))
                                                : ADDR_W'(r_pos - CW'(1));
                    n_state = wsl_pkg::ST_RD_NEXT;
                end
            end
            wsl_pkg::ST_RD_NEXT: begin
                o_mem_addr = ADDR_W'(r_pos + CW'(1));
                n_state = wsl_pkg::ST_RESULT;
            end
            wsl_pkg::ST_RESULT: begin
                o_mem_addr = ADDR_W'(r_pos + CW'(1));
                if (out_free) begin
                    n_state = wsl_pkg::ST_IDLE;
                end
            end
            wsl_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = wsl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wsl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_div_num = (r_g < r_first) ? W'(r_first - r_g) : W'(r_g - rd_ext);
    assign o_div_den = W'(rd_ext - r_first);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == wsl_pkg::ST_RESULT || r_state == wsl_pkg::ST_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wsl_pkg::ST_IDLE: begin
                r_g <= W'(signed'(i_value));
                r_n <= n_clamp;
                r_pos <= CW'(1);
            end
            wsl_pkg::ST_RD_FIRST: begin
                r_first <= rd_ext;
            end
            wsl_pkg::ST_RD_LAST: begin
            end
            wsl_pkg::ST_LATCH_LAST: begin
                r_last  <= rd_ext;
                r_span  <= W'(rd_ext - r_first);
                r_below <= (r_g < r_first);
                if (i_closed_curve && rd_ext <= r_first) begin
                    r_g <= r_first;
                end
            end
            wsl_pkg::ST_DIV: begin
                r_span <= W'(r_last - r_first);
            end
            wsl_pkg::ST_WRAP: begin
                if (r_below) begin
                    r_g <= (i_div_rem == '0) ? r_first
                                             : r_first + signed'(r_span - i_div_rem);
                end else begin
                    r_g <= (i_div_rem == '0) ? r_last : r_first + signed'(i_div_rem);
                end
            end
            wsl_pkg::ST_SEARCH: begin
                if (r_pos < r_n && rd_ext <= r_g) begin
                    r_pos <= r_pos + CW'(1);
                end else begin
                    r_pos <= (r_pos >= r_n) ? r_n - CW'(2) : r_pos - CW'(1);
                end
            end
            wsl_pkg::ST_RD_NEXT: begin
                r_cur <= rd_ext;
            end
            wsl_pkg::ST_RESULT: begin
                if (out_free) begin
                    r_seg_index  <= wsl_pkg::INDEX_W'(r_pos);
                    r_seg_offset <= W'(r_g - r_cur);
                    r_seg_length <= W'(rd_ext - r_cur);
                    r_err        <= 1'b0;
                end
            end
            wsl_pkg::ST_OUT: begin
                if (out_free) begin
                    r_seg_index  <= '0;
                    r_seg_offset <= '0;
                    r_seg_length <= '0;
                    r_err        <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_segment_index  = r_seg_index;
    assign o_segment_offset = r_seg_offset;
    assign o_segment_length = r_seg_length;
    assign o_error_flag     = r_err;
    assign o_busy           = (r_state != wsl_pkg::ST_IDLE) || accept;

endmodule

// File: rtl/wrapped_segment_lookup_core.sv
// ----------------------------------------------------------------------------
// Wrapped segment lookup core
// Breakpoint table with optional wrap of a query and a linear segment search.
// ----------------------------------------------------------------------------
// A write beat is taken in idle, and a query with fewer than two entries in use
// gives an error result. Any other query reads the first and last entries, then
// walks the table one entry per cycle through the single memory port. When a
// closed curve needs wrapping, a 33-step divider and a wrap step run before the
// search. A stalled result only holds the block in its last step. One query is
// handled at a time.
module wrapped_segment_lookup_core #(
    parameter int TABLE_DEPTH = wsl_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits from lowest: entry_index[5:0], value[37:6], zero fill [39:38].
    input  logic [39:0] s_axis_tdata,
    // Bits: cmd[0].
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits from lowest: segment_index[5:0], segment_offset[38:6],
    // segment_length[71:39], zero fill [79:72].
    output logic [79:0] m_axis_tdata,
    // Bits: error_flag[0].
    output logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [wsl_pkg::COUNT_W-1:0] r_entry_count;
    logic                        r_closed_curve;
    logic                        mem_wr_en;
    logic [ADDR_W-1:0]           mem_addr;
    logic [31:0]                 mem_wdata, mem_rdata;
    logic                        div_start, div_done, busy;
    logic [32:0]                 div_num, div_den, div_rem;
    logic [5:0]                  seg_index;
    logic [32:0]                 seg_offset, seg_length;
    logic                        err;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count  <= '0;
            r_closed_curve <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == wsl_pkg::REG_ENTRY_COUNT) begin
                r_entry_count <= i_cfg_data[wsl_pkg::COUNT_W-1:0];
            end else if (i_cfg_index == wsl_pkg::REG_CLOSED_CURVE) begin
                r_closed_curve <= i_cfg_data[0];
            end
        end
    end

    wsl_table #(.TABLE_DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_table (
        .i_clk   (i_clk),
        .i_wr_en (mem_wr_en),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    wsl_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    wsl_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .ADDR_W(ADDR_W)) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_cmd            (s_axis_tuser[0]),
        .i_entry_index    (s_axis_tdata[5:0]),
        .i_value          (s_axis_tdata[37:6]),
        .i_entry_count    (r_entry_count),
        .i_closed_curve   (r_closed_curve),
        .o_mem_wr_en      (mem_wr_en),
        .o_mem_addr       (mem_addr),
        .o_mem_wdata      (mem_wdata),
        .i_mem_rdata      (mem_rdata),
        .o_div_start      (div_start),
        .o_div_num        (div_num),
        .o_div_den        (div_den),
        .i_div_done       (div_done),
        .i_div_rem        (div_rem),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_segment_index  (seg_index),
        .o_segment_offset (seg_offset),
        .o_segment_length (seg_length),
        .o_error_flag     (err),
        .o_busy           (busy)
    );

    assign m_axis_tdata = {8'd0, seg_length, seg_offset, seg_index};
    assign m_axis_tuser = err;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("error result carries nonzero fields");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && !s_axis_tready |=> !(div_start && s_axis_tready))
        else $error("divider start while accepting");
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[5:0] < 6'(TABLE_DEPTH - 1))
        else $error("segment index out of range");
`endif

endmodule
